>>> hdl/mrcm_pkg.sv
`default_nettype none

package mrcm_pkg;

  // Stream geometry
  localparam int RAMP_COUNT        = 4;
  localparam int VALUE_W           = 18;
  localparam int COLOR_W           = 8;
  localparam int CHAN_COUNT        = 3;
  localparam int STOP_COUNT        = 23;
  localparam int STOP_IDX_W        = 5;
  localparam int SEG_W             = 4;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int IN_FIELD_W  = RAMP_COUNT * (VALUE_W + 1);
  localparam int IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = CHAN_COUNT * COLOR_W;

  // Channel order inside a color: red, green, blue
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef logic [COLOR_W-1:0] chan_t;
  typedef logic [CHAN_COUNT-1:0][COLOR_W-1:0] rgb_t;

  // First ROM entry and last segment number of each ramp
  localparam logic [STOP_IDX_W-1:0] RAMP_FIRST [RAMP_COUNT] = '{5'd0, 5'd11, 5'd13, 5'd15};
  localparam logic [SEG_W-1:0] RAMP_LAST_SEG [RAMP_COUNT] = '{4'd10, 4'd1, 4'd1, 4'd7};

  function automatic rgb_t rgb(input chan_t r, input chan_t g, input chan_t b);
    rgb_t c;
    c[CH_RED]   = r;
    c[CH_GREEN] = g;
    c[CH_BLUE]  = b;
    return c;
  endfunction

  // Color stop ROM: blonde, red, white, rainbow ramps back to back
  function automatic rgb_t stop_color(input logic [STOP_IDX_W-1:0] idx);
    rgb_t c;
    unique case (idx)
      5'd0:    c = rgb(8'd0,   8'd0,   8'd0);
      5'd1:    c = rgb(8'd22,  8'd6,   8'd6);
      5'd2:    c = rgb(8'd29,  8'd9,   8'd6);
      5'd3:    c = rgb(8'd45,  8'd21,  8'd11);
      5'd4:    c = rgb(8'd78,  8'd39,  8'd11);
      5'd5:    c = rgb(8'd90,  8'd53,  8'd16);
      5'd6:    c = rgb(8'd136, 8'd92,  8'd21);
      5'd7:    c = rgb(8'd150, 8'd106, 8'd33);
      5'd8:    c = rgb(8'd198, 8'd156, 8'd74);
      5'd9:    c = rgb(8'd233, 8'd192, 8'd103);
      5'd10:   c = rgb(8'd238, 8'd205, 8'd136);
      5'd11:   c = rgb(8'd0,   8'd0,   8'd0);
      5'd12:   c = rgb(8'd118, 8'd47,  8'd19);
      5'd13:   c = rgb(8'd0,   8'd0,   8'd0);
      5'd14:   c = rgb(8'd255, 8'd255, 8'd255);
      5'd15:   c = rgb(8'd0,   8'd0,   8'd0);
      5'd16:   c = rgb(8'd255, 8'd0,   8'd255);
      5'd17:   c = rgb(8'd255, 8'd0,   8'd0);
      5'd18:   c = rgb(8'd255, 8'd255, 8'd0);
      5'd19:   c = rgb(8'd0,   8'd255, 8'd0);
      5'd20:   c = rgb(8'd0,   8'd255, 8'd255);
      5'd21:   c = rgb(8'd0,   8'd0,   8'd255);
      5'd22:   c = rgb(8'd255, 8'd0,   8'd255);
      default: c = rgb(8'd0,   8'd0,   8'd0);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/multi_ramp_color_mixer_unit.sv
// Multi-ramp color mixer.
// Input stream: one request per beat carries four ramp positions, each with a
// presence flag. Each position is clamped to 0..1.0, placed on its own constant
// color ramp (11, 2, 2 and 8 stops) and linearly interpolated; the colors of
// the present ramps are summed and each channel is rounded half up and
// saturated to 0..255. Output stream: one RGB request per input request, in
// order.
// Pipeline: four register stages (segment split, stop lookup and interpolation,
// channel sum, round and saturate); out_tvalid rises when the request reaches
// the output register. Throughput: one request per cycle while the receiver
// does not stall; every stage holds its own valid bit, so bubbles close up.
// The deepest stage is the stop lookup with one small multiply and one add.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When the receiver stalls, the output register holds its request and the
// stages behind it fill one by one before in_tready drops; nothing is lost
// or repeated.
`default_nettype none

module multi_ramp_color_mixer_unit #(
  parameter int FRACTION_BITS = mrcm_pkg::FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // blonde_value, blonde_present, red_value, red_present, white_value,
  // white_present, rainbow_value, rainbow_present, zero pad
  input  logic [mrcm_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // tint_red, tint_green, tint_blue
  output logic [mrcm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import mrcm_pkg::*;

  localparam int FIELD_W = VALUE_W + 1;

  logic [RAMP_COUNT-1:0][VALUE_W-1:0] value;
  logic [RAMP_COUNT-1:0] present;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [RAMP_COUNT-1:0][SEG_W-1:0] seg;
  logic [RAMP_COUNT-1:0][FRACTION_BITS-1:0] frac;
  logic [RAMP_COUNT-1:0] present_s1;
  logic [RAMP_COUNT-1:0][CHAN_COUNT-1:0][FRACTION_BITS+COLOR_W-1:0] term;
  rgb_t tint;

  // Unpack the request fields
  always_comb begin
    for (int r = 0; r < RAMP_COUNT; r++) begin
      value[r]   = in_tdata[r*FIELD_W +: VALUE_W];
      present[r] = in_tdata[r*FIELD_W + VALUE_W];
    end
  end

  // Each stage advances when it is empty or its successor advances
  assign rdy4 = !v4_r || out_tready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_tvalid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  mrcm_seg #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_seg (
    .clk      (clk),
    .en       (rdy1),
    .value    (value),
    .present  (present),
    .seg_r    (seg),
    .frac_r   (frac),
    .present_r(present_s1)
  );

  mrcm_lerp #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_lerp (
    .clk    (clk),
    .en     (rdy2),
    .seg    (seg),
    .frac   (frac),
    .present(present_s1),
    .term_r (term)
  );

  mrcm_mix #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_mix (
    .clk   (clk),
    .sum_en(rdy3),
    .out_en(rdy4),
    .term  (term),
    .tint_r(tint)
  );

  assign out_tvalid = v4_r;
  assign out_tdata  = {tint[CH_BLUE], tint[CH_GREEN], tint[CH_RED]};

endmodule

`default_nettype wire

>>> hdl/mrcm_seg.sv
`default_nettype none

module mrcm_seg #(
  parameter int FRACTION_BITS = mrcm_pkg::FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic en,
  input  logic [mrcm_pkg::RAMP_COUNT-1:0][mrcm_pkg::VALUE_W-1:0] value,
  input  logic [mrcm_pkg::RAMP_COUNT-1:0] present,
  output logic [mrcm_pkg::RAMP_COUNT-1:0][mrcm_pkg::SEG_W-1:0] seg_r,
  output logic [mrcm_pkg::RAMP_COUNT-1:0][FRACTION_BITS-1:0] frac_r,
  output logic [mrcm_pkg::RAMP_COUNT-1:0] present_r
);
  import mrcm_pkg::*;

  localparam int POS_W  = FRACTION_BITS + 1;
  localparam int PROD_W = FRACTION_BITS + SEG_W;
  localparam int CMP_W  = (VALUE_W > POS_W) ? VALUE_W : POS_W;

  logic [CMP_W-1:0] one_ext;
  logic [RAMP_COUNT-1:0][CMP_W-1:0] mag_ext;
  logic [RAMP_COUNT-1:0][POS_W-1:0] pos;
  logic [RAMP_COUNT-1:0][PROD_W-1:0] prod;

  assign one_ext = CMP_W'(1) << FRACTION_BITS;

  // Clamp each position to 0..1.0 and scale by the ramp's segment count
  always_comb begin
    for (int r = 0; r < RAMP_COUNT; r++) begin
      mag_ext[r] = CMP_W'(value[r][VALUE_W-2:0]);
      if (value[r][VALUE_W-1]) begin
        pos[r] = '0;
      end else if (mag_ext[r] > one_ext) begin
        pos[r] = POS_W'(one_ext);
      end else begin
        pos[r] = POS_W'(mag_ext[r]);
      end
      prod[r] = PROD_W'(pos[r]) * PROD_W'(RAMP_LAST_SEG[r]);
    end
  end

  // Split into segment number and fraction
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < RAMP_COUNT; r++) begin
        seg_r[r]  <= prod[r][PROD_W-1:FRACTION_BITS];
        frac_r[r] <= prod[r][FRACTION_BITS-1:0];
      end
      present_r <= present;
    end
  end

endmodule

`default_nettype wire

>>> hdl/mrcm_lerp.sv
`default_nettype none

module mrcm_lerp #(
  parameter int FRACTION_BITS = mrcm_pkg::FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic en,
  input  logic [mrcm_pkg::RAMP_COUNT-1:0][mrcm_pkg::SEG_W-1:0] seg,
  input  logic [mrcm_pkg::RAMP_COUNT-1:0][FRACTION_BITS-1:0] frac,
  input  logic [mrcm_pkg::RAMP_COUNT-1:0] present,
  output logic [mrcm_pkg::RAMP_COUNT-1:0][mrcm_pkg::CHAN_COUNT-1:0]
               [FRACTION_BITS+mrcm_pkg::COLOR_W-1:0] term_r
);
  import mrcm_pkg::*;

  localparam int TERM_W = FRACTION_BITS + COLOR_W;
  localparam int LERP_W = FRACTION_BITS + COLOR_W + 2;

  logic [RAMP_COUNT-1:0][STOP_IDX_W-1:0] idx_a;
  logic [RAMP_COUNT-1:0][STOP_IDX_W-1:0] idx_b;
  rgb_t col_a [RAMP_COUNT];
  rgb_t col_b [RAMP_COUNT];
  logic signed [COLOR_W:0] diff [RAMP_COUNT][CHAN_COUNT];
  logic signed [LERP_W-1:0] prod [RAMP_COUNT][CHAN_COUNT];
  logic [LERP_W-1:0] base [RAMP_COUNT][CHAN_COUNT];
  logic signed [LERP_W-1:0] lerp [RAMP_COUNT][CHAN_COUNT];

  // Look up the bounding stops; the last stop pairs with itself
  always_comb begin
    for (int r = 0; r < RAMP_COUNT; r++) begin
      idx_a[r] = RAMP_FIRST[r] + STOP_IDX_W'(seg[r]);
      if (seg[r] >= RAMP_LAST_SEG[r]) begin
        idx_b[r] = idx_a[r];
      end else begin
        idx_b[r] = idx_a[r] + STOP_IDX_W'(1);
      end
      col_a[r] = stop_color(idx_a[r]);
      col_b[r] = stop_color(idx_b[r]);
    end
  end

  // Interpolate each channel: a * 1.0 + (b - a) * frac
  always_comb begin
    for (int r = 0; r < RAMP_COUNT; r++) begin
      for (int c = 0; c < CHAN_COUNT; c++) begin
        diff[r][c] = $signed({1'b0, col_b[r][c]}) - $signed({1'b0, col_a[r][c]});
        prod[r][c] = LERP_W'(diff[r][c]) * LERP_W'($signed({1'b0, frac[r]}));
        base[r][c] = LERP_W'(col_a[r][c]) << FRACTION_BITS;
        lerp[r][c] = $signed(base[r][c]) + prod[r][c];
      end
    end
  end

  // Drop ramps that are not present
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < RAMP_COUNT; r++) begin
        for (int c = 0; c < CHAN_COUNT; c++) begin
          term_r[r][c] <= present[r] ? TERM_W'(lerp[r][c]) : '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/mrcm_mix.sv
`default_nettype none

module mrcm_mix #(
  parameter int FRACTION_BITS = mrcm_pkg::FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic sum_en,
  input  logic out_en,
  input  logic [mrcm_pkg::RAMP_COUNT-1:0][mrcm_pkg::CHAN_COUNT-1:0]
               [FRACTION_BITS+mrcm_pkg::COLOR_W-1:0] term,
  output mrcm_pkg::rgb_t tint_r
);
  import mrcm_pkg::*;

  localparam int SUM_W = FRACTION_BITS + COLOR_W + 2;
  localparam int Q_W   = SUM_W - FRACTION_BITS;

  logic [CHAN_COUNT-1:0][SUM_W-1:0] sum_nxt;
  logic [CHAN_COUNT-1:0][SUM_W-1:0] sum_r;
  logic [CHAN_COUNT-1:0][SUM_W-1:0] rnd;
  logic [CHAN_COUNT-1:0][Q_W-1:0] q;
  rgb_t tint_nxt;

  // Add the four ramp contributions per channel
  always_comb begin
    for (int c = 0; c < CHAN_COUNT; c++) begin
      sum_nxt[c] = SUM_W'(term[0][c]) + SUM_W'(term[1][c])
                 + SUM_W'(term[2][c]) + SUM_W'(term[3][c]);
    end
  end

  always_ff @(posedge clk) begin
    if (sum_en) begin
      sum_r <= sum_nxt;
    end
  end

  // Round half up and saturate to 255
  always_comb begin
    for (int c = 0; c < CHAN_COUNT; c++) begin
      rnd[c] = sum_r[c] + (SUM_W'(1) << (FRACTION_BITS - 1));
      q[c]   = rnd[c][SUM_W-1:FRACTION_BITS];
      if (q[c] > Q_W'({COLOR_W{1'b1}})) begin
        tint_nxt[c] = '1;
      end else begin
        tint_nxt[c] = q[c][COLOR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      tint_r <= tint_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sim/tint_checker.sv
`timescale 1ns / 100ps

module tint_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_tready,
  input  logic [mrcm_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic out_tvalid,
  input  logic out_tready,
  input  logic [mrcm_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int mismatch_count,
  output int tints_pending
);
  import mrcm_pkg::*;

  localparam int FRAC = FRACTION_BITS_DEF;
  localparam longint ONE = longint'(1) << FRAC;
  localparam int SLOT_W = VALUE_W + 1;

  // Stop colors {r, g, b}: blonde, red, white, rainbow ramps back to back
  localparam int STOP_RGB [23][3] = '{
    '{0, 0, 0}, '{22, 6, 6}, '{29, 9, 6}, '{45, 21, 11}, '{78, 39, 11},
    '{90, 53, 16}, '{136, 92, 21}, '{150, 106, 33}, '{198, 156, 74},
    '{233, 192, 103}, '{238, 205, 136},
    '{0, 0, 0}, '{118, 47, 19},
    '{0, 0, 0}, '{255, 255, 255},
    '{0, 0, 0}, '{255, 0, 255}, '{255, 0, 0}, '{255, 255, 0}, '{0, 255, 0},
    '{0, 255, 255}, '{0, 0, 255}, '{255, 0, 255}
  };
  localparam int RAMP_BASE [4] = '{0, 11, 13, 15};
  localparam int RAMP_STOPS [4] = '{11, 2, 2, 8};

  // Red sits in the lowest byte of out_tdata
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } tint_t;

  tint_t tint_queue [$];
  tint_t want;
  tint_t got;
  int    errs;

  // Sum the present ramps exactly, then round half up and saturate each channel
  function automatic tint_t mix_tint(input logic [IN_TDATA_W-1:0] req);
    longint acc [3];
    longint v, p, seg, frac, a, b, q;
    logic [7:0] chan [3];
    int n, base;
    tint_t t;
    for (int c = 0; c < 3; c++) acc[c] = 0;
    for (int r = 0; r < 4; r++) begin
      if (req[r*SLOT_W + VALUE_W]) begin
        v = longint'($signed(req[r*SLOT_W +: VALUE_W]));
        if (v < 0) v = 0;
        if (v > ONE) v = ONE;
        n = RAMP_STOPS[r];
        base = RAMP_BASE[r];
        p = v * (n - 1);
        seg = p >>> FRAC;
        frac = p & (ONE - 1);
        for (int c = 0; c < 3; c++) begin
          if (seg >= n - 1) begin
            acc[c] += longint'(STOP_RGB[base + n - 1][c]) * ONE;
          end else begin
            a = STOP_RGB[base + int'(seg)][c];
            b = STOP_RGB[base + int'(seg) + 1][c];
            acc[c] += a * ONE + (b - a) * frac;
          end
        end
      end
    end
    for (int c = 0; c < 3; c++) begin
      if (acc[c] < 0) acc[c] = 0;
      q = (acc[c] + (ONE >>> 1)) >>> FRAC;
      if (q > 255) q = 255;
      chan[c] = q[7:0];
    end
    t.red = chan[0];
    t.green = chan[1];
    t.blue = chan[2];
    return t;
  endfunction

  // Predict on each accepted request, compare each accepted result
  always @(posedge clk) begin
    if (!rst_n) begin
      tint_queue.delete();
      errs = 0;
      mismatch_count <= 0;
      tints_pending <= 0;
    end else begin
      if (in_tvalid && in_tready) tint_queue.insert(tint_queue.size(), mix_tint(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (tint_queue.size() == 0) begin
          $error("unexpected result red=%0d green=%0d blue=%0d",
                 got.red, got.green, got.blue);
          errs++;
        end else begin
          want = tint_queue.pop_front();
          if (got.red !== want.red) begin
            $error("tint_red mismatch: expected %0d, got %0d", want.red, got.red);
            errs++;
          end
          if (got.green !== want.green) begin
            $error("tint_green mismatch: expected %0d, got %0d", want.green, got.green);
            errs++;
          end
          if (got.blue !== want.blue) begin
            $error("tint_blue mismatch: expected %0d, got %0d", want.blue, got.blue);
            errs++;
          end
        end
      end
      mismatch_count <= errs;
      tints_pending <= tint_queue.size();
    end
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import mrcm_pkg::*;

  localparam int SLOT_W = VALUE_W + 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // blonde_value, blonde_present, red_value, red_present, white_value,
  // white_present, rainbow_value, rainbow_present, zero pad
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // tint_red, tint_green, tint_blue
  logic [OUT_TDATA_W-1:0] out_tdata;

  int mismatch_count;
  int tints_pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  localparam int PHASE_IDLE [4] = '{0, 51, 0, 32};
  localparam int PHASE_STALL [4] = '{0, 0, 51, 32};

  multi_ramp_color_mixer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  tint_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .tints_pending  (tints_pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the result channel at the current rate
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic logic [IN_TDATA_W-1:0] pack_request(
    input int bv, input bit bp, input int rv, input bit rp,
    input int wv, input bit wp, input int nv, input bit np);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[0*SLOT_W +: VALUE_W] = bv[VALUE_W-1:0];
    d[0*SLOT_W + VALUE_W] = bp;
    d[1*SLOT_W +: VALUE_W] = rv[VALUE_W-1:0];
    d[1*SLOT_W + VALUE_W] = rp;
    d[2*SLOT_W +: VALUE_W] = wv[VALUE_W-1:0];
    d[2*SLOT_W + VALUE_W] = wp;
    d[3*SLOT_W +: VALUE_W] = nv[VALUE_W-1:0];
    d[3*SLOT_W + VALUE_W] = np;
    return d;
  endfunction

  // Mostly in-range positions, with weight on stop boundaries and clamping
  function automatic int pick_position();
    int sel, segs, k, v;
    sel = $urandom_range(99);
    if (sel < 55) begin
      v = $urandom_range(65536);
    end else if (sel < 70) begin
      k = $urandom_range(2);
      segs = (k == 0) ? 10 : (k == 1) ? 1 : 7;
      k = $urandom_range(segs);
      v = (k * 65536 + segs - 1) / segs + int'($urandom_range(2)) - 1;
    end else if (sel < 80) begin
      v = -int'($urandom_range(65536, 1));
    end else if (sel < 92) begin
      v = 65537 + int'($urandom_range(65534));
    end else begin
      v = $urandom_range(1) ? 65536 : 0;
    end
    return v;
  endfunction

  // Hold the request until it is taken, idling beforehand at the current rate
  task automatic send_request(input logic [IN_TDATA_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and wait for every expected result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tints_pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: presence, clamping, stop boundaries, rounding, saturation
    send_request(pack_request(0, 0, 0, 0, 0, 0, 0, 0));
    send_request(pack_request(131071, 0, -65536, 0, 65536, 0, -1, 0));
    send_request(pack_request(0, 1, 0, 0, 0, 0, 0, 0));
    send_request(pack_request(65536, 1, 0, 0, 0, 0, 0, 0));
    send_request(pack_request(-65536, 1, 0, 0, 0, 0, 0, 0));
    send_request(pack_request(131071, 1, 0, 0, 0, 0, 0, 0));
    send_request(pack_request(32768, 1, 0, 0, 0, 0, 0, 0));
    send_request(pack_request(65535, 1, 0, 0, 0, 0, 0, 0));
    send_request(pack_request(0, 0, 32768, 1, 0, 0, 0, 0));
    send_request(pack_request(0, 0, 65536, 1, 0, 0, 0, 0));
    send_request(pack_request(0, 0, 0, 0, 32768, 1, 0, 0));
    send_request(pack_request(0, 0, 0, 0, -1, 1, 0, 0));
    send_request(pack_request(0, 0, 0, 0, 0, 0, 65536, 1));
    send_request(pack_request(0, 0, 0, 0, 0, 0, 9363, 1));
    send_request(pack_request(0, 0, 0, 0, 0, 0, 28087, 1));
    send_request(pack_request(65536, 1, 65536, 1, 65536, 1, 65536, 1));
    send_request(pack_request(32768, 1, 32768, 1, 32768, 1, 32768, 1));
    send_request(pack_request(-65536, 1, -65536, 1, -65536, 1, -65536, 1));
    send_request(pack_request(0, 0, 65535, 1, 65535, 1, 0, 0));
    send_request(pack_request(6554, 1, 1, 1, 65536, 0, 65535, 1));
    send_request(pack_request(131071, 1, 131071, 1, 131071, 1, 131071, 1));
    drain_results();

    // Random requests under each idle and stall pattern
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = PHASE_IDLE[ph];
      recv_stall_pct = PHASE_STALL[ph];
      repeat (110) begin
        send_request(pack_request(
          pick_position(), 1'($urandom_range(1)),
          pick_position(), 1'($urandom_range(1)),
          pick_position(), 1'($urandom_range(1)),
          pick_position(), 1'($urandom_range(1))));
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && tints_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1600000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
